/* rtl/mep_pkg.sv */
// Shared constants, types and status codes for the mesh edge twin pairing block.
package mep_pkg;

    localparam int EDGE_SLOTS    = 1024;
    localparam int VERTEX_BITS   = 16;
    localparam int FACE_BITS     = 16;
    localparam int SLOT_BITS     = $clog2(EDGE_SLOTS);
    localparam int CNT_BITS      = SLOT_BITS + 1;
    localparam int OPEN_BITS     = $clog2(EDGE_SLOTS + 1);
    localparam int KEY_BITS      = 2 * VERTEX_BITS;
    localparam int KEY_WORD_BITS = KEY_BITS + 1;
    localparam int OWNER_BITS    = FACE_BITS + VERTEX_BITS;
    localparam int FIELD_BITS    = 16;
    localparam int OPEN_OUT_BITS = 11;

    typedef logic [FIELD_BITS-1:0]    field_t;
    typedef logic [OPEN_OUT_BITS-1:0] open_out_t;
    typedef logic [VERTEX_BITS-1:0]   vertex_t;
    typedef logic [FACE_BITS-1:0]     face_t;
    typedef logic [SLOT_BITS-1:0]     slot_t;
    typedef logic [CNT_BITS-1:0]      cnt_t;
    typedef logic [OPEN_BITS-1:0]     open_t;
    typedef logic [KEY_WORD_BITS-1:0] key_word_t;
    typedef logic [OWNER_BITS-1:0]    owner_word_t;

    typedef enum logic [1:0] {
        ST_OPEN   = 2'd0,
        ST_PAIRED = 2'd1,
        ST_DUP    = 2'd2,
        ST_FULL   = 2'd3
    } edge_status_t;

    typedef struct packed {
        field_t       edge_start;
        field_t       edge_end;
        field_t       first_face;
        field_t       first_opposite;
        field_t       second_face;
        field_t       second_opposite;
        edge_status_t edge_status;
        logic         last_of_triangle;
        open_out_t    open_edges;
    } result_t;

endpackage

/* rtl/mep_face_if.sv */
// Triangle input channel: valid/ready with three vertex indices.
interface mep_face_if;
    logic            valid;
    logic            ready;
    mep_pkg::field_t vertex_a;
    mep_pkg::field_t vertex_b;
    mep_pkg::field_t vertex_c;

    modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                    input ready);
    modport sink (input valid, input vertex_a, input vertex_b, input vertex_c,
                  output ready);
endinterface

/* rtl/mep_edge_if.sv */
// Edge result channel: valid/ready with one edge result per transfer.
interface mep_edge_if;
    logic                  valid;
    logic                  ready;
    mep_pkg::field_t       edge_start;
    mep_pkg::field_t       edge_end;
    mep_pkg::field_t       first_face;
    mep_pkg::field_t       first_opposite;
    mep_pkg::field_t       second_face;
    mep_pkg::field_t       second_opposite;
    logic [1:0]            edge_status;
    logic                  last_of_triangle;
    mep_pkg::open_out_t    open_edges;

    modport source (output valid, output edge_start, output edge_end, output first_face,
                    output first_opposite, output second_face, output second_opposite,
                    output edge_status, output last_of_triangle, output open_edges,
                    input ready);
    modport sink (input valid, input edge_start, input edge_end, input first_face,
                  input first_opposite, input second_face, input second_opposite,
                  input edge_status, input last_of_triangle, input open_edges,
                  output ready);
endinterface

/* rtl/mesh_edge_twin_pairing.sv */
// Each edge of a triangle is handled by a scan of every key RAM slot through the one read
// port and comparator, then a decision, and for a paired or duplicate edge an owner read;
// the results leave one edge at a time. A new triangle is taken only after the last
// edge result of the current one has entered the output register.
// A result still waiting in the output register holds the next result back.
// Reset: asynchronous, active low; every key RAM slot is cleared before the first triangle.
module mesh_edge_twin_pairing (
    input  logic               clk,
    input  logic               rst_n,
    mep_face_if.sink           face_in,
    mep_edge_if.source         edge_out
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_OWNER  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    state_t                state_reg, state_next;
    mep_pkg::cnt_t         cnt_reg, cnt_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    mep_pkg::slot_t        cmp_idx_reg, cmp_idx_next;
    logic                  rev_hit_reg, rev_hit_next;
    mep_pkg::slot_t        rev_idx_reg, rev_idx_next;
    logic                  dup_hit_reg, dup_hit_next;
    mep_pkg::slot_t        dup_idx_reg, dup_idx_next;
    logic                  free_hit_reg, free_hit_next;
    mep_pkg::slot_t        free_idx_reg, free_idx_next;
    mep_pkg::vertex_t      va_reg, va_next;
    mep_pkg::vertex_t      vb_reg, vb_next;
    mep_pkg::vertex_t      vc_reg, vc_next;
    mep_pkg::face_t        face_reg, face_next;
    mep_pkg::face_t        face_cnt_reg, face_cnt_next;
    mep_pkg::open_t        open_cnt_reg, open_cnt_next;
    logic [1:0]            edge_idx_reg, edge_idx_next;
    mep_pkg::edge_status_t stat_reg, stat_next;
    mep_pkg::result_t      res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    mep_pkg::result_t      out_reg, out_next;

    mep_pkg::vertex_t      s_v, e_v, opp_v;
    logic                  last_edge;
    logic                  key_we;
    mep_pkg::slot_t        key_waddr, key_raddr;
    mep_pkg::key_word_t    key_wdata, key_rdata;
    logic                  owner_we;
    mep_pkg::slot_t        owner_waddr, owner_raddr;
    mep_pkg::owner_word_t  owner_wdata, owner_rdata;
    mep_pkg::face_t        own_face;
    mep_pkg::vertex_t      own_opp;

    mep_ram #(
        .WIDTH (mep_pkg::KEY_WORD_BITS),
        .DEPTH (mep_pkg::EDGE_SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    mep_ram #(
        .WIDTH (mep_pkg::OWNER_BITS),
        .DEPTH (mep_pkg::EDGE_SLOTS)
    ) u_owner_ram (
        .clk   (clk),
        .we    (owner_we),
        .waddr (owner_waddr),
        .wdata (owner_wdata),
        .raddr (owner_raddr),
        .rdata (owner_rdata)
    );

    always_comb
    begin
        case (edge_idx_reg)
            EDGE_AB:
            begin
                s_v = va_reg; e_v = vb_reg; opp_v = vc_reg;
            end
            EDGE_BC:
            begin
                s_v = vb_reg; e_v = vc_reg; opp_v = va_reg;
            end
            EDGE_CA:
            begin
                s_v = vc_reg; e_v = va_reg; opp_v = vb_reg;
            end
            default:
            begin
                s_v = va_reg; e_v = vb_reg; opp_v = vc_reg;
            end
        endcase
    end

    assign last_edge = (edge_idx_reg == EDGE_CA);
    assign own_face  = owner_rdata[mep_pkg::OWNER_BITS-1:mep_pkg::VERTEX_BITS];
    assign own_opp   = owner_rdata[mep_pkg::VERTEX_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        rev_hit_next   = rev_hit_reg;
        rev_idx_next   = rev_idx_reg;
        dup_hit_next   = dup_hit_reg;
        dup_idx_next   = dup_idx_reg;
        free_hit_next  = free_hit_reg;
        free_idx_next  = free_idx_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vc_next        = vc_reg;
        face_next      = face_reg;
        face_cnt_next  = face_cnt_reg;
        open_cnt_next  = open_cnt_reg;
        edge_idx_next  = edge_idx_reg;
        stat_next      = stat_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !edge_out.ready;

        key_we      = 1'b0;
        key_waddr   = cnt_reg[mep_pkg::SLOT_BITS-1:0];
        key_wdata   = '0;
        key_raddr   = cnt_reg[mep_pkg::SLOT_BITS-1:0];
        owner_we    = 1'b0;
        owner_waddr = free_idx_reg;
        owner_wdata = {face_reg, opp_v};
        owner_raddr = rev_idx_reg;

        // one slot compared per cycle, lowest match wins
        if (cmp_valid_reg)
        begin
            if (key_rdata[mep_pkg::KEY_BITS])
            begin
                if (!rev_hit_reg && key_rdata[mep_pkg::KEY_BITS-1:0] == {e_v, s_v})
                begin
                    rev_hit_next = 1'b1;
                    rev_idx_next = cmp_idx_reg;
                end
                if (!dup_hit_reg && key_rdata[mep_pkg::KEY_BITS-1:0] == {s_v, e_v})
                begin
                    dup_hit_next = 1'b1;
                    dup_idx_next = cmp_idx_reg;
                end
            end
            else if (!free_hit_reg)
            begin
                free_hit_next = 1'b1;
                free_idx_next = cmp_idx_reg;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                key_we = 1'b1;
                if (cnt_reg == mep_pkg::cnt_t'(mep_pkg::EDGE_SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (face_in.valid)
                begin
                    va_next       = face_in.vertex_a[mep_pkg::VERTEX_BITS-1:0];
                    vb_next       = face_in.vertex_b[mep_pkg::VERTEX_BITS-1:0];
                    vc_next       = face_in.vertex_c[mep_pkg::VERTEX_BITS-1:0];
                    face_next     = face_cnt_reg;
                    edge_idx_next = EDGE_AB;
                    cnt_next      = '0;
                    rev_hit_next  = 1'b0;
                    dup_hit_next  = 1'b0;
                    free_hit_next = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != mep_pkg::cnt_t'(mep_pkg::EDGE_SLOTS))
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = cnt_reg[mep_pkg::SLOT_BITS-1:0];
                    cnt_next       = cnt_reg + 1'b1;
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (rev_hit_reg)
                begin
                    key_we      = 1'b1;
                    key_waddr   = rev_idx_reg;
                    key_wdata   = '0;
                    owner_raddr = rev_idx_reg;
                    if (open_cnt_reg != '0)
                    begin
                        open_cnt_next = open_cnt_reg - 1'b1;
                    end
                    stat_next  = mep_pkg::ST_PAIRED;
                    state_next = S_OWNER;
                end
                else if (dup_hit_reg)
                begin
                    owner_raddr = dup_idx_reg;
                    stat_next   = mep_pkg::ST_DUP;
                    state_next  = S_OWNER;
                end
                else if (free_hit_reg)
                begin
                    key_we        = 1'b1;
                    key_waddr     = free_idx_reg;
                    key_wdata     = {1'b1, s_v, e_v};
                    owner_we      = 1'b1;
                    open_cnt_next = open_cnt_reg + 1'b1;
                    res_next.edge_start       = mep_pkg::field_t'(s_v);
                    res_next.edge_end         = mep_pkg::field_t'(e_v);
                    res_next.first_face       = mep_pkg::field_t'(face_reg);
                    res_next.first_opposite   = mep_pkg::field_t'(opp_v);
                    res_next.second_face      = '0;
                    res_next.second_opposite  = '0;
                    res_next.edge_status      = mep_pkg::ST_OPEN;
                    res_next.last_of_triangle = last_edge;
                    res_next.open_edges       = mep_pkg::open_out_t'(open_cnt_reg + 1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    res_next.edge_start       = mep_pkg::field_t'(s_v);
                    res_next.edge_end         = mep_pkg::field_t'(e_v);
                    res_next.first_face       = '0;
                    res_next.first_opposite   = '0;
                    res_next.second_face      = mep_pkg::field_t'(face_reg);
                    res_next.second_opposite  = mep_pkg::field_t'(opp_v);
                    res_next.edge_status      = mep_pkg::ST_FULL;
                    res_next.last_of_triangle = last_edge;
                    res_next.open_edges       = mep_pkg::open_out_t'(open_cnt_reg);
                    state_next = S_EMIT;
                end
            end
            S_OWNER:
            begin
                if (stat_reg == mep_pkg::ST_PAIRED)
                begin
                    res_next.edge_start = mep_pkg::field_t'(e_v);
                    res_next.edge_end   = mep_pkg::field_t'(s_v);
                end
                else
                begin
                    res_next.edge_start = mep_pkg::field_t'(s_v);
                    res_next.edge_end   = mep_pkg::field_t'(e_v);
                end
                res_next.first_face       = mep_pkg::field_t'(own_face);
                res_next.first_opposite   = mep_pkg::field_t'(own_opp);
                res_next.second_face      = mep_pkg::field_t'(face_reg);
                res_next.second_opposite  = mep_pkg::field_t'(opp_v);
                res_next.edge_status      = stat_reg;
                res_next.last_of_triangle = last_edge;
                res_next.open_edges       = mep_pkg::open_out_t'(open_cnt_reg);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || edge_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    if (last_edge)
                    begin
                        if (face_cnt_reg != '1)
                        begin
                            face_cnt_next = face_cnt_reg + 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        edge_idx_next = edge_idx_reg + 1'b1;
                        cnt_next      = '0;
                        rev_hit_next  = 1'b0;
                        dup_hit_next  = 1'b0;
                        free_hit_next = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            rev_hit_reg   <= 1'b0;
            dup_hit_reg   <= 1'b0;
            free_hit_reg  <= 1'b0;
            face_cnt_reg  <= '0;
            open_cnt_reg  <= '0;
            edge_idx_reg  <= EDGE_AB;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            rev_hit_reg   <= rev_hit_next;
            dup_hit_reg   <= dup_hit_next;
            free_hit_reg  <= free_hit_next;
            face_cnt_reg  <= face_cnt_next;
            open_cnt_reg  <= open_cnt_next;
            edge_idx_reg  <= edge_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        rev_idx_reg  <= rev_idx_next;
        dup_idx_reg  <= dup_idx_next;
        free_idx_reg <= free_idx_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        vc_reg       <= vc_next;
        face_reg     <= face_next;
        stat_reg     <= stat_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign face_in.ready             = (state_reg == S_IDLE);
    assign edge_out.valid            = out_valid_reg;
    assign edge_out.edge_start       = out_reg.edge_start;
    assign edge_out.edge_end         = out_reg.edge_end;
    assign edge_out.first_face       = out_reg.first_face;
    assign edge_out.first_opposite   = out_reg.first_opposite;
    assign edge_out.second_face      = out_reg.second_face;
    assign edge_out.second_opposite  = out_reg.second_opposite;
    assign edge_out.edge_status      = out_reg.edge_status;
    assign edge_out.last_of_triangle = out_reg.last_of_triangle;
    assign edge_out.open_edges       = out_reg.open_edges;

endmodule

/* rtl/mep_ram.sv */
// Generic simple dual-port RAM with registered read.
module mep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mep_checker.sv */
// Port-level assertions for the mesh edge twin pairing block, bound to the top level.
module mep_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input mep_pkg::field_t    first_face,
    input mep_pkg::field_t    first_opposite,
    input mep_pkg::field_t    second_face,
    input mep_pkg::field_t    second_opposite,
    input logic [1:0]         edge_status,
    input mep_pkg::open_out_t open_edges
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held after triangle transfer");

    a_owner_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (edge_status == mep_pkg::ST_PAIRED || edge_status == mep_pkg::ST_DUP)
        |-> first_face <= second_face)
        else $error("earlier owner has a later face number");

    a_open_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && edge_status == mep_pkg::ST_OPEN
        |-> second_face == '0 && second_opposite == '0 && open_edges != '0)
        else $error("stored edge result malformed");

    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && edge_status == mep_pkg::ST_FULL
        |-> first_face == '0 && first_opposite == '0
            && open_edges == mep_pkg::open_out_t'(mep_pkg::EDGE_SLOTS))
        else $error("table full result malformed");

endmodule

bind mesh_edge_twin_pairing mep_checker u_mep_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (face_in.valid),
    .in_ready        (face_in.ready),
    .out_valid       (edge_out.valid),
    .out_ready       (edge_out.ready),
    .first_face      (edge_out.first_face),
    .first_opposite  (edge_out.first_opposite),
    .second_face     (edge_out.second_face),
    .second_opposite (edge_out.second_opposite),
    .edge_status     (edge_out.edge_status),
    .open_edges      (edge_out.open_edges)
);

/* test/mesh_edge_twin_pairing_tb.sv */
// Self-checking testbench for mesh_edge_twin_pairing: edge table predictor and random meshes.
`timescale 1ns / 1ps

module mesh_edge_twin_pairing_tb;

    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int     DRAIN_CYCLES = 3200;

    typedef logic [mep_pkg::KEY_BITS-1:0] key_t;

    class edge_twin_predictor;
        key_t              key_tbl [mep_pkg::EDGE_SLOTS];
        mep_pkg::face_t    owner_face [mep_pkg::EDGE_SLOTS];
        mep_pkg::vertex_t  owner_opp [mep_pkg::EDGE_SLOTS];
        bit                live [mep_pkg::EDGE_SLOTS];
        mep_pkg::face_t    face_cnt;
        int unsigned       open_cnt;
        int unsigned       errors;
        mep_pkg::result_t  pending_edges [$];

        function new();
            foreach (live[i])
                live[i] = 1'b0;
            face_cnt = '0;
            open_cnt = 0;
            errors   = 0;
        endfunction

        function void walk_edge(mep_pkg::vertex_t s, mep_pkg::vertex_t e,
                                mep_pkg::face_t face, mep_pkg::vertex_t opp,
                                logic is_last);
            mep_pkg::result_t r;
            int               twin_at;
            int               dup_at;
            int               free_at;
            twin_at = -1;
            dup_at  = -1;
            free_at = -1;
            r = '0;
            r.last_of_triangle = is_last;
            for (int i = 0; i < mep_pkg::EDGE_SLOTS; i++)
            begin
                if (live[i] && key_tbl[i] == {e, s})
                begin
                    twin_at = i;
                    break;
                end
            end
            if (twin_at >= 0)
            begin
                live[twin_at] = 1'b0;
                if (open_cnt > 0)
                    open_cnt--;
                r.edge_start      = e;
                r.edge_end        = s;
                r.first_face      = owner_face[twin_at];
                r.first_opposite  = owner_opp[twin_at];
                r.second_face     = face;
                r.second_opposite = opp;
                r.edge_status     = mep_pkg::ST_PAIRED;
            end
            else
            begin
                for (int i = 0; i < mep_pkg::EDGE_SLOTS; i++)
                begin
                    if (live[i])
                    begin
                        if (dup_at < 0 && key_tbl[i] == {s, e})
                            dup_at = i;
                    end
                    else if (free_at < 0)
                    begin
                        free_at = i;
                    end
                end
                r.edge_start = s;
                r.edge_end   = e;
                if (dup_at >= 0)
                begin
                    r.first_face      = owner_face[dup_at];
                    r.first_opposite  = owner_opp[dup_at];
                    r.second_face     = face;
                    r.second_opposite = opp;
                    r.edge_status     = mep_pkg::ST_DUP;
                end
                else if (free_at < 0)
                begin
                    r.second_face     = face;
                    r.second_opposite = opp;
                    r.edge_status     = mep_pkg::ST_FULL;
                end
                else
                begin
                    key_tbl[free_at]    = {s, e};
                    owner_face[free_at] = face;
                    owner_opp[free_at]  = opp;
                    live[free_at]       = 1'b1;
                    open_cnt++;
                    r.first_face     = face;
                    r.first_opposite = opp;
                    r.edge_status    = mep_pkg::ST_OPEN;
                end
            end
            r.open_edges = mep_pkg::open_out_t'(open_cnt);
            pending_edges.insert(pending_edges.size(), r);
        endfunction

        function void note_triangle(mep_pkg::vertex_t a, mep_pkg::vertex_t b,
                                    mep_pkg::vertex_t c);
            mep_pkg::face_t face;
            face = face_cnt;
            walk_edge(a, b, face, c, 1'b0);
            walk_edge(b, c, face, a, 1'b0);
            walk_edge(c, a, face, b, 1'b1);
            if (face_cnt != {mep_pkg::FACE_BITS{1'b1}})
                face_cnt++;
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s expected %0d got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_edge(mep_pkg::result_t got);
            mep_pkg::result_t want;
            if (pending_edges.size() == 0)
            begin
                $error("edge result with no prediction pending");
                errors++;
                return;
            end
            want = pending_edges.pop_front();
            check_field("edge_start", want.edge_start, got.edge_start);
            check_field("edge_end", want.edge_end, got.edge_end);
            check_field("first_face", want.first_face, got.first_face);
            check_field("first_opposite", want.first_opposite, got.first_opposite);
            check_field("second_face", want.second_face, got.second_face);
            check_field("second_opposite", want.second_opposite, got.second_opposite);
            check_field("edge_status", want.edge_status, got.edge_status);
            check_field("last_of_triangle", want.last_of_triangle, got.last_of_triangle);
            check_field("open_edges", want.open_edges, got.open_edges);
        endfunction

        // random open edge, so the stimulus can build its twin
        function bit pick_open(output mep_pkg::vertex_t s, output mep_pkg::vertex_t e);
            int unsigned start;
            s = '0;
            e = '0;
            start = $urandom_range(mep_pkg::EDGE_SLOTS - 1);
            for (int k = 0; k < mep_pkg::EDGE_SLOTS; k++)
            begin
                int unsigned j;
                j = (start + k) % mep_pkg::EDGE_SLOTS;
                if (live[j])
                begin
                    s = key_tbl[j][mep_pkg::KEY_BITS-1:mep_pkg::VERTEX_BITS];
                    e = key_tbl[j][mep_pkg::VERTEX_BITS-1:0];
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    longint            cycle_cnt = 0;
    int unsigned       src_idle_pct;
    int unsigned       snk_idle_pct;
    mep_pkg::vertex_t  prev_tri [3];

    edge_twin_predictor pairing = new();

    mep_face_if face_if();
    mep_edge_if edge_if();

    mesh_edge_twin_pairing u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .face_in  (face_if),
        .edge_out (edge_if)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (edge_if.valid && edge_if.ready)
            pairing.check_edge({edge_if.edge_start, edge_if.edge_end, edge_if.first_face,
                                edge_if.first_opposite, edge_if.second_face,
                                edge_if.second_opposite,
                                mep_pkg::edge_status_t'(edge_if.edge_status),
                                edge_if.last_of_triangle, edge_if.open_edges});
        edge_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_face(input mep_pkg::vertex_t a, input mep_pkg::vertex_t b,
                             input mep_pkg::vertex_t c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            face_if.valid <= 1'b0;
            @(posedge clk);
        end
        face_if.valid    <= 1'b1;
        face_if.vertex_a <= a;
        face_if.vertex_b <= b;
        face_if.vertex_c <= c;
        do
            @(posedge clk);
        while (!face_if.ready);
        pairing.note_triangle(a, b, c);
        prev_tri[0] = a;
        prev_tri[1] = b;
        prev_tri[2] = c;
    endtask

    task automatic send_fresh();
        send_face(mep_pkg::vertex_t'($urandom), mep_pkg::vertex_t'($urandom),
                  mep_pkg::vertex_t'($urandom));
    endtask

    // mostly twins of open edges, so meshes grow and close; the rest is noise
    task automatic send_mesh_item();
        mep_pkg::vertex_t s;
        mep_pkg::vertex_t e;
        mep_pkg::vertex_t x;
        mep_pkg::vertex_t t [3];
        int unsigned      roll;
        int unsigned      rot;
        roll = $urandom_range(99);
        x = $urandom_range(1) ? mep_pkg::vertex_t'($urandom)
                              : mep_pkg::vertex_t'($urandom_range(15));
        if (roll < 55 && pairing.pick_open(s, e))
        begin
            t[0] = e;
            t[1] = s;
            t[2] = x;
        end
        else if (roll < 75)
        begin
            t[0] = mep_pkg::vertex_t'($urandom_range(15));
            t[1] = mep_pkg::vertex_t'($urandom_range(15));
            t[2] = mep_pkg::vertex_t'($urandom_range(15));
        end
        else if (roll < 88)
        begin
            t[0] = mep_pkg::vertex_t'($urandom);
            t[1] = mep_pkg::vertex_t'($urandom);
            t[2] = mep_pkg::vertex_t'($urandom);
        end
        else if (roll < 94)
        begin
            t = prev_tri;
        end
        else
        begin
            t[0] = prev_tri[2];
            t[1] = prev_tri[1];
            t[2] = prev_tri[0];
        end
        rot = $urandom_range(2);
        send_face(t[rot], t[(rot + 1) % 3], t[(rot + 2) % 3]);
    endtask

    initial
    begin
        prev_tri[0] = '0;
        prev_tri[1] = '0;
        prev_tri[2] = '0;
        src_idle_pct = 16;
        snk_idle_pct = 64;
        rst_n            <= 1'b0;
        face_if.valid    <= 1'b0;
        face_if.vertex_a <= '0;
        face_if.vertex_b <= '0;
        face_if.vertex_c <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // store, duplicate, reverse pairing
        send_face(16'd0, 16'd1, 16'd2);
        send_face(16'd0, 16'd1, 16'd2);
        send_face(16'd2, 16'd1, 16'd0);
        // extreme vertex values
        send_face(16'hFFFF, 16'h0000, 16'hAAAA);
        send_face(16'h0000, 16'hFFFF, 16'h5555);
        send_face(16'h5555, 16'hFFFF, 16'hAAAA);
        send_face(16'h8000, 16'h7FFF, 16'h0001);
        // degenerate edges
        send_face(16'd7, 16'd7, 16'd9);
        send_face(16'd7, 16'd7, 16'd7);
        send_face(16'd9, 16'd7, 16'd7);
        send_face(16'd3, 16'd3, 16'd3);
        send_face(16'd3, 16'd3, 16'd4);
        send_face(16'hFFFF, 16'hFFFF, 16'h0000);
        // small fan of neighbors
        send_face(16'd10, 16'd11, 16'd12);
        send_face(16'd12, 16'd11, 16'd13);
        send_face(16'd13, 16'd11, 16'd14);
        send_face(16'd10, 16'd12, 16'd11);
        send_face(16'd14, 16'd11, 16'd10);

        repeat (55) send_mesh_item();

        src_idle_pct = 64;
        snk_idle_pct = 16;
        // fresh triangles mixed with mesh growth
        for (int i = 0; i < 60; i++)
        begin
            if (i % 2 == 0)
                send_fresh();
            else
                send_mesh_item();
        end

        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (55) send_mesh_item();

        face_if.valid <= 1'b0;
        while (pairing.pending_edges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pairing.errors == 0 && pairing.pending_edges.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
